@@ hw/rtl/ipv4hv_pkg.sv @@
// shared types, codes and helpers for the ipv4 header validator
package ipv4hv_pkg;

    // verdict codes
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_VERSION     = 4'd2,
        ST_IHL         = 4'd3,
        ST_HDR_PAST    = 4'd4,
        ST_LENGTH      = 4'd5,
        ST_CHECKSUM    = 4'd6,
        ST_FRAGMENT    = 4'd7,
        ST_NOT_OURS    = 4'd8
    } t_status;

    // configuration register indexes
    typedef enum logic {
        REG_LOCAL_ADDR = 1'b0,
        REG_TRUST_HW   = 1'b1
    } t_reg_index;

    // header word positions of the fields we keep
    localparam logic [4:0] IDX_TOTAL_LEN = 5'd1;
    localparam logic [4:0] IDX_FRAG      = 5'd3;
    localparam logic [4:0] IDX_PROTO     = 5'd4;
    localparam logic [4:0] IDX_DST_HI    = 5'd8;
    localparam logic [4:0] IDX_DST_LO    = 5'd9;

    localparam logic [3:0]  IPV4_VERSION = 4'd4;
    localparam logic [3:0]  IHL_MIN      = 4'd5;
    localparam logic [15:0] MIN_FRAME    = 16'd20;
    localparam logic [15:0] MF_FLAG      = 16'h2000;
    localparam logic [15:0] OFFSET_MASK  = 16'h1FFF;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

    // one verdict from the checking core
    typedef struct packed {
        logic       valid;
        t_status    status;
        logic [7:0] protocol;
        logic [5:0] header_bytes;
    } t_result;

    // ones' complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

@@ hw/rtl/ipv4hv_core.sv @@
// header collection state and verdict logic, one word per advance
module ipv4hv_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [15:0]          i_header_word,
    input  logic                 i_first_word,
    input  logic [15:0]          i_frame_bytes,
    input  logic                 i_hw_checksum_good,
    input  logic [31:0]          i_local_address,
    input  logic                 i_trust_hw_checksum,
    output ipv4hv_pkg::t_result  o_result
);

    logic [4:0]  r_word_index,   n_word_index;
    logic [4:0]  r_header_words, n_header_words;
    logic [15:0] r_running_sum,  n_running_sum;
    logic [15:0] r_total_length, n_total_length;
    logic [15:0] r_fragment,     n_fragment;
    logic [7:0]  r_protocol,     n_protocol;
    logic [31:0] r_destination,  n_destination;
    logic [15:0] r_frame_length, n_frame_length;
    logic        r_hw_good,      n_hw_good;
    logic        r_active,       n_active;

    logic [3:0]  ihl;
    logic        last_word;

    assign ihl       = i_header_word[11:8];
    assign last_word = ({1'b0, r_word_index} + 6'd1) >= {1'b0, r_header_words};

    // next state and verdict for the word at the input register
    always_comb begin
        n_word_index   = r_word_index;
        n_header_words = r_header_words;
        n_running_sum  = r_running_sum;
        n_total_length = r_total_length;
        n_fragment     = r_fragment;
        n_protocol     = r_protocol;
        n_destination  = r_destination;
        n_frame_length = r_frame_length;
        n_hw_good      = r_hw_good;
        n_active       = r_active;
        o_result       = '{valid: 1'b0, status: ipv4hv_pkg::ST_OK,
                           protocol: 8'd0, header_bytes: 6'd0};

        if (i_first_word) begin
            n_frame_length = i_frame_bytes;
            n_hw_good      = i_hw_checksum_good;
            n_active       = 1'b0;
            o_result.valid = 1'b1;
            if (i_frame_bytes < ipv4hv_pkg::MIN_FRAME) begin
                o_result.status = ipv4hv_pkg::ST_SHORT;
            end else if (i_header_word[15:12] != ipv4hv_pkg::IPV4_VERSION) begin
                o_result.status = ipv4hv_pkg::ST_VERSION;
            end else if (ihl < ipv4hv_pkg::IHL_MIN) begin
                o_result.status = ipv4hv_pkg::ST_IHL;
            end else if ({10'd0, ihl, 2'b00} > i_frame_bytes) begin
                o_result.status = ipv4hv_pkg::ST_HDR_PAST;
            end else begin
                // first-word checks pass, start collecting
                o_result.valid = 1'b0;
                n_header_words = {ihl, 1'b0};
                n_word_index   = 5'd1;
                n_running_sum  = i_header_word;
                n_total_length = 16'd0;
                n_fragment     = 16'd0;
                n_protocol     = 8'd0;
                n_destination  = 32'd0;
                n_active       = 1'b1;
            end
        end else if (r_active) begin
            n_running_sum = ipv4hv_pkg::oc_add(r_running_sum, i_header_word);
            case (r_word_index)
                ipv4hv_pkg::IDX_TOTAL_LEN: n_total_length = i_header_word;
                ipv4hv_pkg::IDX_FRAG:      n_fragment     = i_header_word;
                ipv4hv_pkg::IDX_PROTO:     n_protocol     = i_header_word[7:0];
                ipv4hv_pkg::IDX_DST_HI:    n_destination[31:16] = i_header_word;
                ipv4hv_pkg::IDX_DST_LO:    n_destination[15:0]  = i_header_word;
                default: ;
            endcase

            if (!last_word) begin
                n_word_index = r_word_index + 5'd1;
            end else begin
                // final verdict uses the values updated by this word
                n_active       = 1'b0;
                o_result.valid = 1'b1;
                if (n_total_length > r_frame_length) begin
                    o_result.status = ipv4hv_pkg::ST_LENGTH;
                end else if (!(i_trust_hw_checksum && r_hw_good)
                             && n_running_sum != ipv4hv_pkg::SUM_GOOD) begin
                    o_result.status = ipv4hv_pkg::ST_CHECKSUM;
                end else if ((n_fragment & (ipv4hv_pkg::MF_FLAG
                                            | ipv4hv_pkg::OFFSET_MASK)) != 16'd0) begin
                    o_result.status = ipv4hv_pkg::ST_FRAGMENT;
                end else if (i_local_address != 32'd0
                             && n_destination != i_local_address) begin
                    o_result.status = ipv4hv_pkg::ST_NOT_OURS;
                end else begin
                    o_result.protocol     = n_protocol;
                    o_result.header_bytes = {r_header_words, 1'b0};
                end
            end
        end
    end

    // collection state, updated only when the word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_advance) begin
            r_active <= n_active;
        end
        if (i_advance) begin
            r_word_index   <= n_word_index;
            r_header_words <= n_header_words;
            r_running_sum  <= n_running_sum;
            r_total_length <= n_total_length;
            r_fragment     <= n_fragment;
            r_protocol     <= n_protocol;
            r_destination  <= n_destination;
            r_frame_length <= n_frame_length;
            r_hw_good      <= n_hw_good;
        end
    end

endmodule

@@ hw/rtl/ipv4_header_validator.sv @@
// top level of the ipv4 header validator: stream ports, registers, config port
//
// Header words enter on the slave stream, one 16-bit word per transaction,
// with tuser[0] marking the first word of a header; frame length and the
// hardware checksum flag ride along and are sampled on that first word.
// One verdict per header leaves on the master stream: on the first word
// when an early check fails, otherwise on the last header word (IHL*2).
// Stray words before a first word and abandoned headers give no verdict.
// A word is taken into an input register, checked by the core and its
// verdict, if any, lands in an output register. One word is accepted
// every cycle while the receiver does not stall; the limit is the
// one-word checksum add and compare path between the two registers.
// When the receiver stalls the verdict holds in the output register; the
// input register still takes one more word, after which tready falls.
// Reset clears both valid flags and the collection state; registers
// local_address (0x0) and trust_hw_checksum (0x4) reset to zero; the user
// writes them over APB only while the block is idle (not enforced here).
module ipv4_header_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // header_word[15:0], frame_bytes[31:16]
    input  logic [1:0]  i_s_axis_tuser,   // first_word[0], hw_checksum_good[1]
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // status[3:0], protocol[11:4],
                                          // header_bytes[17:12], zero[23:18]
    // configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic        r_in_valid;
    logic [15:0] r_header_word;
    logic        r_first_word;
    logic [15:0] r_frame_bytes;
    logic        r_hw_good;

    logic        r_out_valid;
    ipv4hv_pkg::t_status r_status;
    logic [7:0]  r_protocol;
    logic [5:0]  r_header_bytes;

    logic [31:0] r_local_address;
    logic        r_trust_hw;

    logic        advance;
    logic        cfg_write;
    ipv4hv_pkg::t_reg_index reg_sel;
    ipv4hv_pkg::t_result    result;

    // word moves from the input register when the output side has room
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_header_word <= i_s_axis_tdata[15:0];
            r_frame_bytes <= i_s_axis_tdata[31:16];
            r_first_word  <= i_s_axis_tuser[0];
            r_hw_good     <= i_s_axis_tuser[1];
        end
    end

    ipv4hv_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_advance           (advance),
        .i_header_word       (r_header_word),
        .i_first_word        (r_first_word),
        .i_frame_bytes       (r_frame_bytes),
        .i_hw_checksum_good  (r_hw_good),
        .i_local_address     (r_local_address),
        .i_trust_hw_checksum (r_trust_hw),
        .o_result            (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && result.valid) begin
            r_status       <= result.status;
            r_protocol     <= result.protocol;
            r_header_bytes <= result.header_bytes;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_header_bytes, r_protocol, r_status};

    // configuration registers
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign reg_sel   = ipv4hv_pkg::t_reg_index'(i_paddr[2]);
    assign o_pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= 32'd0;
            r_trust_hw      <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                ipv4hv_pkg::REG_LOCAL_ADDR: r_local_address <= i_pwdata;
                ipv4hv_pkg::REG_TRUST_HW:   r_trust_hw      <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_sel)
            ipv4hv_pkg::REG_LOCAL_ADDR: o_prdata = r_local_address;
            ipv4hv_pkg::REG_TRUST_HW:   o_prdata = {31'd0, r_trust_hw};
            default:                    o_prdata = 32'd0;
        endcase
    end

    // checks on the block's own logic
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid not cleared by reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled with an empty output register");

    a_reject_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ipv4hv_pkg::ST_OK
        |-> r_protocol == 8'd0 && r_header_bytes == 6'd0)
        else $error("rejected header carries protocol or length");

    a_ok_min_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ipv4hv_pkg::ST_OK |-> r_header_bytes >= 6'd20)
        else $error("accepted header shorter than twenty bytes");

endmodule

@@ verif/ipv4hv_checker.sv @@
// checker for the ipv4 header validator: predicts verdicts from accepted words and compares
module ipv4hv_checker
    import ipv4hv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream as seen on the wires
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // header_word[15:0], frame_bytes[31:16]
    input  logic [1:0]  i_s_axis_tuser,   // first_word[0], hw_checksum_good[1]
    // master stream as seen on the wires
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] i_m_axis_tdata,   // status[3:0], protocol[11:4],
                                          // header_bytes[17:12], zero[23:18]
    // configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    // verdicts still owed by the block, and mismatches so far
    output logic [15:0] o_waiting,
    output int          o_fail_count
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        t_status    status;
        logic [7:0] protocol;
        logic [5:0] header_bytes;
    } t_verdict;

    t_verdict    verdict_q[$];
    int          fail_total = 0;

    // our copy of the registers
    logic [31:0] cfg_local_addr;
    logic        cfg_trust_hw;

    // header collection state
    logic        collecting;
    logic [4:0]  word_pos;
    logic [4:0]  word_total;
    logic [15:0] sum_acc;
    logic [15:0] tot_len;
    logic [15:0] frag_word;
    logic [7:0]  proto_byte;
    logic [31:0] dest_ip;
    logic [15:0] frame_len;
    logic        hw_good;

    assign o_fail_count = fail_total;

    // 16-bit add with the carry wrapped back in
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_total < PRINT_CAP) begin
            $display("checker: %0t: %s", $time, msg);
        end
        fail_total++;
    endtask

    task automatic post_verdict(input t_status st, input logic [7:0] proto,
                                input logic [5:0] nbytes);
        verdict_q.push_back('{status: st, protocol: proto, header_bytes: nbytes});
        collecting = 1'b0;
    endtask

    // one accepted header word
    task automatic predict_word(input logic [15:0] word, input logic first,
                                input logic [15:0] frame, input logic hw);
        logic [3:0] ihl;
        ihl = word[11:8];
        if (first) begin
            // early checks, answered on the first word
            frame_len  = frame;
            hw_good    = hw;
            collecting = 1'b0;
            if (frame < MIN_FRAME) begin
                post_verdict(ST_SHORT, 8'd0, 6'd0);
            end else if (word[15:12] != IPV4_VERSION) begin
                post_verdict(ST_VERSION, 8'd0, 6'd0);
            end else if (ihl < IHL_MIN) begin
                post_verdict(ST_IHL, 8'd0, 6'd0);
            end else if ({10'd0, ihl, 2'b00} > frame) begin
                post_verdict(ST_HDR_PAST, 8'd0, 6'd0);
            end else begin
                word_total = {ihl, 1'b0};
                word_pos   = 5'd1;
                sum_acc    = word;
                tot_len    = '0;
                frag_word  = '0;
                proto_byte = '0;
                dest_ip    = '0;
                collecting = 1'b1;
            end
        end else if (collecting) begin
            sum_acc = ones_add(sum_acc, word);
            case (word_pos)
                IDX_TOTAL_LEN: tot_len = word;
                IDX_FRAG:      frag_word = word;
                IDX_PROTO:     proto_byte = word[7:0];
                IDX_DST_HI:    dest_ip[31:16] = word;
                IDX_DST_LO:    dest_ip[15:0] = word;
                default: ;
            endcase
            // late checks, answered on the last header word
            if (word_pos + 5'd1 < word_total) begin
                word_pos = word_pos + 5'd1;
            end else if (tot_len > frame_len) begin
                post_verdict(ST_LENGTH, 8'd0, 6'd0);
            end else if (!(cfg_trust_hw && hw_good) && sum_acc != SUM_GOOD) begin
                post_verdict(ST_CHECKSUM, 8'd0, 6'd0);
            end else if ((frag_word & (MF_FLAG | OFFSET_MASK)) != '0) begin
                post_verdict(ST_FRAGMENT, 8'd0, 6'd0);
            end else if (cfg_local_addr != '0 && dest_ip != cfg_local_addr) begin
                post_verdict(ST_NOT_OURS, 8'd0, 6'd0);
            end else begin
                post_verdict(ST_OK, proto_byte, {word_total, 1'b0});
            end
        end
    endtask

    // one verdict leaving the block against the oldest one owed
    task automatic check_verdict(input logic [23:0] data);
        t_verdict want;
        if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("verdict %h with none owed", data));
        end else begin
            want = verdict_q.pop_front();
            if (data[3:0] != want.status) begin
                report_mismatch($sformatf("status %0d, wanted %0d", data[3:0], want.status));
            end
            if (data[11:4] != want.protocol) begin
                report_mismatch($sformatf("protocol %h, wanted %h", data[11:4], want.protocol));
            end
            if (data[17:12] != want.header_bytes) begin
                report_mismatch($sformatf("header bytes %0d, wanted %0d",
                                          data[17:12], want.header_bytes));
            end
        end
    endtask

    // watch every edge: registers, outgoing verdicts, then incoming words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            verdict_q.delete();
            cfg_local_addr = '0;
            cfg_trust_hw   = 1'b0;
            collecting     = 1'b0;
            word_pos       = '0;
            word_total     = '0;
            sum_acc        = '0;
            tot_len        = '0;
            frag_word      = '0;
            proto_byte     = '0;
            dest_ip        = '0;
            frame_len      = '0;
            hw_good        = 1'b0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_index'(i_paddr[2]))
                    REG_LOCAL_ADDR: cfg_local_addr = i_pwdata;
                    REG_TRUST_HW:   cfg_trust_hw = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                check_verdict(i_m_axis_tdata);
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_word(i_s_axis_tdata[15:0], i_s_axis_tuser[0],
                             i_s_axis_tdata[31:16], i_s_axis_tuser[1]);
            end
        end
        o_waiting <= 16'(verdict_q.size());
    end

endmodule

@@ verif/tb_top.sv @@
// testbench top for the ipv4 header validator: clock, reset, stimulus and verdict
module tb_top;
    import ipv4hv_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int PHASES       = 8;

    // receiver pacing styles
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_pace;

    // header flavours for the random part
    typedef enum {
        HK_GOOD,
        HK_SHORT,
        HK_VERSION,
        HK_IHL,
        HK_PAST,
        HK_LENGTH,
        HK_CHECKSUM,
        HK_TRUSTED,
        HK_FRAGMENT,
        HK_FOREIGN,
        HK_ABANDON,
        HK_STRAY
    } t_hdr_kind;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // header_word[15:0], frame_bytes[31:16]
    logic [1:0]  s_tuser = '0;   // first_word[0], hw_checksum_good[1]

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // status[3:0], protocol[11:4], header_bytes[17:12]

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [15:0] waiting;
    int          fail_count;
    int          cycle_count = 0;

    // sender pacing
    logic        pace_gaps = 1'b0;
    int          burst_left = 0;

    // receiver pacing and long hold-off requests
    t_rx_pace    rx_pace = RX_FREE;
    int          rx_left = 0;
    int          hold_left = 0;
    int          holds_asked = 0;
    int          holds_served = 0;

    // register values the stimulus aims at
    logic [31:0] cur_local = '0;
    logic        cur_trust = 1'b0;

    logic [15:0] hdr_buf [30];

    ipv4_header_validator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    ipv4hv_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_waiting       (waiting),
        .o_fail_count    (fail_count)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: long hold-offs on request, otherwise a pacing style per stretch
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_pace <= t_rx_pace'($urandom_range(3, 0));
                rx_left <= $urandom_range(200, 20);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_pace)
                RX_FREE:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom);
                RX_SPARSE: m_tready <= ($urandom_range(3, 0) == 0);
                default:   m_tready <= rx_left[2];
            endcase
        end
    end

    // fold a plain sum down to a 16-bit end-around sum
    function automatic logic [15:0] ones_fold(input logic [31:0] acc);
        logic [31:0] t;
        t = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
        return t[15:0];
    endfunction

    // offer one word and wait for its transaction, with burst gaps when pacing
    task automatic push_word(input logic [15:0] word, input logic first,
                             input logic [15:0] frame, input logic hw);
        int gap;
        gap = 0;
        if (pace_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(16, 1);
                gap = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 8)
                                                  : $urandom_range(4, 1);
            end
            burst_left--;
        end
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {frame, word};
        s_tuser  <= {hw, first};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop offering and wait until every owed verdict is out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access, then back to idle
    task automatic reg_write(input t_reg_index idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // fill the header buffer with random content and a correct checksum
    task automatic build_header(input logic [3:0] ihl, input logic [15:0] tot,
                                input logic [15:0] frag, input logic [7:0] proto,
                                input logic [31:0] dst);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < 30; i++) hdr_buf[i] = 16'($urandom);
        hdr_buf[0]      = {IPV4_VERSION, ihl, hdr_buf[0][7:0]};
        hdr_buf[1]      = tot;
        hdr_buf[3]      = frag;
        hdr_buf[4][7:0] = proto;
        hdr_buf[5]      = '0;
        hdr_buf[8]      = dst[31:16];
        hdr_buf[9]      = dst[15:0];
        for (int i = 0; i < 2 * ihl; i++) acc += hdr_buf[i];
        hdr_buf[5] = ~ones_fold(acc);
    endtask

    // send the first n words of the buffer; later words carry random side fields
    task automatic send_words(input int n, input logic [15:0] frame, input logic hw,
                              inout int sent);
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                push_word(hdr_buf[0], 1'b1, frame, hw);
            end else begin
                push_word(hdr_buf[i], 1'b0, 16'($urandom), 1'($urandom));
            end
        end
        sent += n;
    endtask

    // one random header, well formed or broken in one way, or stray words
    task automatic random_header(inout int sent);
        t_hdr_kind   kind;
        int          pick;
        int          nwords;
        logic [3:0]  ihl;
        logic [3:0]  ihl_big;
        logic [3:0]  ver;
        logic [15:0] frame;
        logic [15:0] tot;
        logic [15:0] frag;
        logic [31:0] dst;
        logic        hw;
        pick = $urandom_range(99, 0);
        if (pick < 45)      kind = HK_GOOD;
        else if (pick < 49) kind = HK_SHORT;
        else if (pick < 53) kind = HK_VERSION;
        else if (pick < 57) kind = HK_IHL;
        else if (pick < 61) kind = HK_PAST;
        else if (pick < 66) kind = HK_LENGTH;
        else if (pick < 72) kind = HK_CHECKSUM;
        else if (pick < 77) kind = HK_TRUSTED;
        else if (pick < 83) kind = HK_FRAGMENT;
        else if (pick < 89) kind = HK_FOREIGN;
        else if (pick < 95) kind = HK_ABANDON;
        else                kind = HK_STRAY;

        ihl    = ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 6)) : IHL_MIN;
        nwords = 2 * ihl;
        hw     = 1'($urandom);
        frame  = 16'($urandom_range(65535, 4 * ihl));
        tot    = ($urandom_range(3, 0) == 0) ? frame : 16'($urandom_range(frame, 0));
        frag   = {2'($urandom), 14'd0};
        dst    = (cur_local == '0) ? 32'($urandom) : cur_local;

        case (kind)
            HK_LENGTH: begin
                frame = 16'($urandom_range(65534, 4 * ihl));
                tot   = 16'($urandom_range(65535, frame + 1));
            end
            HK_FRAGMENT: begin
                frag = 16'($urandom);
                if ((frag & (MF_FLAG | OFFSET_MASK)) == '0) frag = frag | MF_FLAG;
            end
            HK_FOREIGN: begin
                dst = dst ^ (32'($urandom) | (32'd1 << $urandom_range(31, 0)));
            end
            default: ;
        endcase
        build_header(ihl, tot, frag, 8'($urandom), dst);

        case (kind)
            HK_STRAY: begin
                // words with no first word before them
                repeat ($urandom_range(3, 1)) begin
                    push_word(16'($urandom), 1'b0, 16'($urandom), 1'($urandom));
                end
            end
            HK_SHORT: begin
                hdr_buf[0] = 16'($urandom);
                send_words(1, 16'($urandom_range(19, 0)), hw, sent);
            end
            HK_VERSION: begin
                ver = 4'($urandom_range(14, 0));
                if (ver >= IPV4_VERSION) ver = ver + 4'd1;
                hdr_buf[0][15:12] = ver;
                send_words(1, frame, hw, sent);
            end
            HK_IHL: begin
                hdr_buf[0][11:8] = 4'($urandom_range(4, 0));
                send_words(1, frame, hw, sent);
            end
            HK_PAST: begin
                ihl_big = 4'($urandom_range(15, 6));
                hdr_buf[0][11:8] = ihl_big;
                send_words(1, 16'($urandom_range(4 * ihl_big - 1, 20)), hw, sent);
            end
            HK_CHECKSUM, HK_TRUSTED: begin
                hdr_buf[5] = hdr_buf[5] ^ 16'($urandom_range(65535, 1));
                if (kind == HK_TRUSTED) hw = 1'b1;
                send_words(nwords, frame, hw, sent);
            end
            HK_ABANDON: begin
                // cut short; the next first word takes over
                send_words($urandom_range(nwords - 1, 1), frame, hw, sent);
            end
            default: begin
                send_words(nwords, frame, hw, sent);
            end
        endcase
    endtask

    // main sequence
    initial begin
        int phase;
        int sent;
        sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: early verdicts at their edges, a stray word, a restart
        push_word(16'h4500, 1'b1, 16'd0, 1'b0);
        push_word(16'hFFFF, 1'b1, 16'd19, 1'b1);
        push_word(16'hF5FF, 1'b1, 16'hFFFF, 1'b0);
        push_word(16'h0500, 1'b1, 16'd20, 1'b1);
        push_word(16'h4400, 1'b1, 16'd20, 1'b0);
        push_word(16'h4000, 1'b1, 16'hFFFF, 1'b1);
        push_word(16'h4F00, 1'b1, 16'd59, 1'b0);
        push_word(16'hFFFF, 1'b0, 16'hFFFF, 1'b1);
        push_word(16'h4500, 1'b1, 16'd20, 1'b0);
        // full-size frame and length, all-ones protocol and destination
        build_header(IHL_MIN, 16'hFFFF, 16'h0000, 8'hFF, 32'hFFFF_FFFF);
        send_words(2 * IHL_MIN, 16'hFFFF, 1'b1, sent);
        settle();

        // random phases, each with its own register settings and pacing
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase % 3)
                0:       cur_local = '0;
                1:       cur_local = 32'hFFFF_FFFF;
                default: cur_local = 32'($urandom);
            endcase
            cur_trust = phase[0];
            reg_write(REG_LOCAL_ADDR, cur_local);
            reg_write(REG_TRUST_HW, {31'd0, cur_trust});
            pace_gaps = (phase % 4 != 2);
            if (phase == 3 || phase == 6) holds_asked <= holds_asked + 1;
            sent = 0;
            while (sent < PHASE_ITEMS) random_header(sent);
            settle();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
